/* src/pst_pkg.sv */
// ----------------------------------------------------------------------------
// pst_pkg
// Shared types and codes for the spanning tree core: beat layouts of the
// item and result channels, result kinds and register indexes.
// ----------------------------------------------------------------------------
package pst_pkg;

    // Field widths fixed by the channel definitions
    localparam int VERTEX_FIELD_W = 4;
    localparam int WEIGHT_FIELD_W = 16;
    localparam int KIND_W         = 2;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 5;

    // Item actions
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_RUN   = 1'b1;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_EDGE       = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EMPTY      = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NOT_CONN   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_UNWEIGHTED = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHTED_MODE = 1'd1;

    typedef struct packed {
        logic                      action;
        logic [VERTEX_FIELD_W-1:0] from_vertex;
        logic [VERTEX_FIELD_W-1:0] to_vertex;
        logic [WEIGHT_FIELD_W-1:0] edge_weight;
    } t_in_item;

    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic [VERTEX_FIELD_W-1:0] parent_vertex;
        logic [VERTEX_FIELD_W-1:0] child_vertex;
        logic [WEIGHT_FIELD_W-1:0] tree_weight;
        logic                      last;
    } t_out_item;

endpackage

/* src/pst_ram.sv */
// ----------------------------------------------------------------------------
// pst_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module pst_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one word and read one word; the read data comes out of a register
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/prim_spanning_tree_core.sv */
// ----------------------------------------------------------------------------
// prim_spanning_tree_core
// Minimum spanning tree over a directed weight matrix, grown from vertex 0
// with Prim's method. The matrix and the per-vertex key/parent/join state
// live in two synchronous RAMs that are walked one entry per cycle.
//
//   channel  | direction | beat
//   ---------+-----------+----------------------------------------------
//   in       | input     | t_in_item: matrix write or run request
//   out      | output    | t_out_item: tree edge, empty marker or error
//   cfg      | input     | vertex_count / weighted_mode register write
//
// A run grows the tree by sweeping the state RAM through its single read
// port once for every joined vertex but the last, then emits its beats
// one at a time, each held until the consumer takes it.
// After reset all MAX_VERTICES squared matrix RAM entries (256 at the
// default) are cleared, with o_in_ready low. The core takes one item at a
// time and holds each result until i_out_ready accepts it.
// ----------------------------------------------------------------------------
module prim_spanning_tree_core
    import pst_pkg::*;
#(
    parameter int MAX_VERTICES = 16,
    parameter int WEIGHT_BITS  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int VB  = $clog2(MAX_VERTICES);
    localparam int CW  = $clog2(MAX_VERTICES + 1);
    localparam int NW  = (CW > CFG_DATA_W) ? CW : CFG_DATA_W;
    localparam int KW  = WEIGHT_BITS + 1;
    localparam int SW  = VB + KW;
    localparam int WD  = MAX_VERTICES * MAX_VERTICES;
    localparam int AW  = $clog2(WD);
    localparam int SAW = $clog2(2 * MAX_VERTICES);

    localparam logic [KW-1:0] KEY_NONE = KW'(1) << WEIGHT_BITS;

    // State codes
    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_JOIN   = 4'd2;
    localparam logic [3:0] S_PASS   = 4'd3;
    localparam logic [3:0] S_DRAIN  = 4'd4;
    localparam logic [3:0] S_DECIDE = 4'd5;
    localparam logic [3:0] S_FINISH = 4'd6;
    localparam logic [3:0] S_EJOIN  = 4'd7;
    localparam logic [3:0] S_EPAR   = 4'd8;
    localparam logic [3:0] S_EW     = 4'd9;
    localparam logic [3:0] S_ELOAD  = 4'd10;
    localparam logic [3:0] S_OUT    = 4'd11;

    logic [3:0]              r_state;
    logic [AW-1:0]           r_clr;
    logic [CFG_DATA_W-1:0]   r_vcount;
    logic                    r_weighted;
    logic [MAX_VERTICES-1:0] r_in_tree;
    logic [VB-1:0]           r_pick;
    logic [VB-1:0]           r_step;
    logic [VB-1:0]           r_v;
    logic                    r_rd_vld;
    logic [VB-1:0]           r_rd_v;
    logic [KW-1:0]           r_low;
    logic [VB-1:0]           r_best;
    logic [VB-1:0]           r_idx;
    logic [VB-1:0]           r_child;
    logic [VB-1:0]           r_parent;
    t_out_item               r_out;

    logic [CW-1:0]  n_count;
    logic [CW-1:0]  n_count_m1;
    logic           in_beat;
    logic           out_beat;

    // Matrix RAM ports
    logic            wm_we;
    logic [AW-1:0]   wm_waddr;
    logic [WEIGHT_BITS-1:0] wm_wdata;
    logic [AW-1:0]   wm_raddr;
    logic [WEIGHT_BITS-1:0] wm_rdata;

    // State RAM ports: keys/parents in the low half, join order in the high half
    logic            st_we;
    logic [SAW-1:0]  st_waddr;
    logic [SW-1:0]   st_wdata;
    logic [SAW-1:0]  st_raddr;
    logic [SW-1:0]   st_rdata;

    // Pass datapath
    logic [KW-1:0]   old_key;
    logic [VB-1:0]   old_par;
    logic [KW-1:0]   new_key;
    logic [VB-1:0]   new_par;
    logic            upd;
    logic            cand;
    logic            wr_ok;
    logic [NW-1:0]   n_ext;

    // Active vertex count, capped at the array size
    always_comb begin
        n_ext = NW'(r_vcount);
        if (n_ext > NW'(MAX_VERTICES)) begin
            n_ext = NW'(MAX_VERTICES);
        end
        n_count    = CW'(n_ext);
        n_count_m1 = n_count - CW'(1);
    end

    assign in_beat  = i_in_valid && o_in_ready;
    assign out_beat = o_out_valid && i_out_ready;
    assign wr_ok    = (NW'(i_in_data.from_vertex) < n_ext)
                   && (NW'(i_in_data.to_vertex) < n_ext);

    // Relax one candidate vertex against the newly joined one
    always_comb begin
        if (r_step == '0) begin
            old_key = KEY_NONE;
            old_par = '0;
        end else begin
            old_key = st_rdata[KW-1:0];
            old_par = st_rdata[SW-1:KW];
        end
        upd = (wm_rdata != '0) && !r_in_tree[r_rd_v] && ({1'b0, wm_rdata} < old_key);
        if (upd) begin
            new_key = {1'b0, wm_rdata};
            new_par = r_pick;
        end else begin
            new_key = old_key;
            new_par = old_par;
        end
        cand = !r_in_tree[r_rd_v] && (new_key < r_low);
    end

    // Matrix RAM: clearing sweep or item write; reads for pass and emit
    always_comb begin
        wm_we    = 1'b0;
        wm_waddr = r_clr;
        wm_wdata = '0;
        if (r_state == S_CLEAR) begin
            wm_we = 1'b1;
        end else if (in_beat && (i_in_data.action == ACT_WRITE) && wr_ok) begin
            wm_we    = 1'b1;
            wm_waddr = AW'(i_in_data.from_vertex) * AW'(MAX_VERTICES)
                     + AW'(i_in_data.to_vertex);
            wm_wdata = WEIGHT_BITS'(i_in_data.edge_weight);
        end
        if (r_state == S_EW) begin
            wm_raddr = AW'(st_rdata[SW-1:KW]) * AW'(MAX_VERTICES) + AW'(r_child);
        end else begin
            wm_raddr = AW'(r_pick) * AW'(MAX_VERTICES) + AW'(r_v);
        end
    end

    // State RAM: key writeback during a pass, join entry on join
    always_comb begin
        st_we    = 1'b0;
        st_waddr = SAW'(r_rd_v);
        st_wdata = {new_par, new_key};
        if (r_rd_vld) begin
            st_we = 1'b1;
        end else if (r_state == S_JOIN) begin
            st_we    = 1'b1;
            st_waddr = SAW'(MAX_VERTICES) + SAW'(r_step);
            st_wdata = SW'(r_pick);
        end
        unique case (r_state)
            S_EJOIN: st_raddr = SAW'(MAX_VERTICES) + SAW'(r_idx);
            S_EPAR:  st_raddr = SAW'(st_rdata[VB-1:0]);
            default: st_raddr = SAW'(r_v);
        endcase
    end

    pst_ram #(
        .WIDTH (WEIGHT_BITS),
        .DEPTH (WD)
    ) u_matrix_ram (
        .i_clk   (i_clk),
        .i_we    (wm_we),
        .i_waddr (wm_waddr),
        .i_wdata (wm_wdata),
        .i_raddr (wm_raddr),
        .o_rdata (wm_rdata)
    );

    pst_ram #(
        .WIDTH (SW),
        .DEPTH (2 * MAX_VERTICES)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount   <= '0;
            r_weighted <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_VERTEX_COUNT:  r_vcount   <= i_cfg_data;
                REG_WEIGHTED_MODE: r_weighted <= i_cfg_data[0];
                default:           r_weighted <= r_weighted;
            endcase
        end
    end

    // Pass pipeline: track the lowest key among vertices still outside
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= (r_state == S_PASS);
        end
        r_rd_v <= r_v;
        if (r_state == S_JOIN) begin
            r_low <= KEY_NONE;
        end else if (r_rd_vld && cand) begin
            r_low  <= new_key;
            r_best <= r_rd_v;
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_in_tree <= '0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(WD - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_beat && (i_in_data.action == ACT_RUN)) begin
                        if (n_count == '0) begin
                            r_out   <= '{KIND_EMPTY, '0, '0, '0, 1'b1};
                            r_state <= S_OUT;
                        end else begin
                            r_in_tree <= '0;
                            r_pick    <= '0;
                            r_step    <= '0;
                            r_state   <= S_JOIN;
                        end
                    end
                end
                S_JOIN: begin
                    r_in_tree[r_pick] <= 1'b1;
                    r_v <= '0;
                    if (CW'(r_step) == n_count_m1) begin
                        r_state <= S_FINISH;
                    end else begin
                        r_state <= S_PASS;
                    end
                end
                S_PASS: begin
                    r_v <= r_v + VB'(1);
                    if (CW'(r_v) == n_count_m1) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    if (r_low == KEY_NONE) begin
                        r_out   <= '{KIND_NOT_CONN, '0, '0, '0, 1'b1};
                        r_state <= S_OUT;
                    end else begin
                        r_pick  <= r_best;
                        r_step  <= r_step + VB'(1);
                        r_state <= S_JOIN;
                    end
                end
                S_FINISH: begin
                    if (!r_weighted) begin
                        r_out   <= '{KIND_UNWEIGHTED, '0, '0, '0, 1'b1};
                        r_state <= S_OUT;
                    end else if (n_count == CW'(1)) begin
                        r_out   <= '{KIND_EMPTY, '0, '0, '0, 1'b1};
                        r_state <= S_OUT;
                    end else begin
                        r_idx   <= VB'(1);
                        r_state <= S_EJOIN;
                    end
                end
                S_EJOIN: begin
                    r_state <= S_EPAR;
                end
                S_EPAR: begin
                    r_child <= st_rdata[VB-1:0];
                    r_state <= S_EW;
                end
                S_EW: begin
                    r_parent <= st_rdata[SW-1:KW];
                    r_state  <= S_ELOAD;
                end
                S_ELOAD: begin
                    r_out.kind          <= KIND_EDGE;
                    r_out.parent_vertex <= VERTEX_FIELD_W'(r_parent);
                    r_out.child_vertex  <= VERTEX_FIELD_W'(r_child);
                    r_out.tree_weight   <= WEIGHT_FIELD_W'(wm_rdata);
                    r_out.last          <= (CW'(r_idx) == n_count_m1);
                    r_state             <= S_OUT;
                end
                S_OUT: begin
                    if (out_beat) begin
                        if (r_out.last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx   <= r_idx + VB'(1);
                            r_state <= S_EJOIN;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_out_data  = r_out;

endmodule
